### design/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point arithmetic unit.
// No dependencies; used by fixed_point_alu_q24_8, fpa_checker and testbench.
package fpa_pkg;

  localparam int unsigned WordBits     = 32;
  localparam int unsigned FracBitsDef  = 8;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_MIN     = 4'd4,
    OP_MAX     = 4'd5,
    OP_INC     = 4'd6,
    OP_DEC     = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT  = 4'd9
  } op_e;

  // Everything except the divider state that rides along the pipeline.
  typedef struct packed {
    logic                is_div;
    logic                is_mul;
    logic                div_zero;
    logic                neg;
    logic                greater;
    logic                less;
    logic                equal;
    logic [WordBits-1:0] value;
  } side_t;

endpackage

### design/fixed_point_alu_q24_8.sv
// Top level of the pipelined signed fixed-point arithmetic unit.
// Depends on fpa_pkg for the opcode enum, the side-band struct and widths.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  in      | in_valid_i  | in_stall_o  | req_type_i, operand_a_i, operand_b_i
//  out     | out_valid_o | out_stall_i | value_o, greater_o, less_o, equal_o,
//          |             |             | divide_by_zero_o
//
// One beat enters per cycle while the output is not stalled; every beat passes WordBits + FRAC_BITS + 2 register stages
// (42 at the default), set by the divider, which resolves one quotient bit per stage.
// All operations pass the same stages, so results leave in order.
// Reset clears only the valid bits of the pipeline; payload registers are unreset.
// When the output beat is stalled the whole pipeline holds, and the input stalls too.
module fixed_point_alu_q24_8
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 req_type_i,
  input  logic signed [WordBits-1:0] operand_a_i,
  input  logic signed [WordBits-1:0] operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [WordBits-1:0] value_o,
  output logic                       greater_o,
  output logic                       less_o,
  output logic                       equal_o,
  output logic                       divide_by_zero_o
);

  // Quotient bits: the shifted dividend magnitude needs WordBits + FRAC_BITS bits.
  localparam int unsigned QBits = WordBits + FRAC_BITS;

  // The pipeline advances whenever the output register is free or being taken.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------------
  // Entry stage: comparisons, the cheap operations, the product and the
  // divider operands in magnitude form.
  // ---------------------------------------------------------------------------
  op_e                        op;
  side_t                      side_d;
  logic signed [2*WordBits-1:0] prod_d;
  logic [WordBits-1:0]        a_mag, b_mag;
  logic [QBits-1:0]           num_d;

  assign op = op_e'(req_type_i);

  always_comb begin
    side_d          = '0;
    side_d.greater  = operand_a_i > operand_b_i;
    side_d.less     = operand_a_i < operand_b_i;
    side_d.equal    = operand_a_i == operand_b_i;
    side_d.is_div   = (op == OP_DIV);
    side_d.is_mul   = (op == OP_MUL);
    side_d.div_zero = (op == OP_DIV) && (operand_b_i == '0);
    side_d.neg      = operand_a_i[WordBits-1] ^ operand_b_i[WordBits-1];
    case (op)
      OP_ADD:      side_d.value = operand_a_i + operand_b_i;
      OP_SUB:      side_d.value = operand_a_i - operand_b_i;
      OP_MIN:      side_d.value = side_d.less ? operand_a_i : operand_b_i;
      OP_MAX:      side_d.value = side_d.greater ? operand_a_i : operand_b_i;
      OP_INC:      side_d.value = operand_a_i + WordBits'(1);
      OP_DEC:      side_d.value = operand_a_i - WordBits'(1);
      OP_FROM_INT: side_d.value = operand_a_i << FRAC_BITS;
      OP_TO_INT:   side_d.value = operand_a_i >>> FRAC_BITS;
      default:     side_d.value = '0;
    endcase
  end

  assign prod_d = operand_a_i * operand_b_i;
  assign a_mag  = operand_a_i[WordBits-1] ? WordBits'(-operand_a_i) : operand_a_i;
  assign b_mag  = operand_b_i[WordBits-1] ? WordBits'(-operand_b_i) : operand_b_i;
  assign num_d  = {a_mag, {FRAC_BITS{1'b0}}};

  // Stage registers, index 0 is the entry stage, 1..QBits the divider steps.
  logic                         vld_q  [0:QBits];
  side_t                        side_q [0:QBits];
  logic [WordBits-1:0]          rem_q  [0:QBits];
  logic [QBits-1:0]             num_q  [0:QBits];
  logic [WordBits-1:0]          dvs_q  [0:QBits];
  logic signed [2*WordBits-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      prod_q    <= prod_d;
      rem_q[0]  <= '0;
      num_q[0]  <= num_d;
      dvs_q[0]  <= b_mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage. The dividend shifts out at
  // the top of num while quotient bits shift in at the bottom.
  // ---------------------------------------------------------------------------
  for (genvar j = 1; j <= QBits; j++) begin : g_div
    logic [WordBits:0]   trial;
    logic [WordBits+1:0] diff;
    logic                ge;
    side_t               side_n;
    logic signed [2*WordBits-1:0] shifted;

    assign trial   = {rem_q[j-1], num_q[j-1][QBits-1]};
    assign diff    = {1'b0, trial} - {2'b00, dvs_q[j-1]};
    assign ge      = !diff[WordBits+1];
    assign shifted = prod_q >>> FRAC_BITS;

    // The product is folded into the side value on the first step.
    always_comb begin
      side_n = side_q[j-1];
      if (j == 1 && side_q[j-1].is_mul) begin
        side_n.value = shifted[WordBits-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[j] <= side_n;
        rem_q[j]  <= ge ? diff[WordBits-1:0] : trial[WordBits-1:0];
        num_q[j]  <= {num_q[j-1][QBits-2:0], ge};
        dvs_q[j]  <= dvs_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: sign the quotient and pick the result.
  // ---------------------------------------------------------------------------
  side_t               last;
  logic [WordBits-1:0] quo;
  logic [WordBits-1:0] res_d;
  logic                out_vld_q;
  logic [WordBits-1:0] value_q;
  logic                gt_q, lt_q, eq_q, dz_q;

  assign last = side_q[QBits];
  assign quo  = num_q[QBits][WordBits-1:0];

  always_comb begin
    if (last.is_div) begin
      if (last.div_zero) begin
        res_d = '0;
      end else begin
        res_d = last.neg ? WordBits'(-quo) : quo;
      end
    end else begin
      res_d = last.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q <= res_d;
      gt_q    <= last.greater;
      lt_q    <= last.less;
      eq_q    <= last.equal;
      dz_q    <= last.div_zero;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign value_o          = value_q;
  assign greater_o        = gt_q;
  assign less_o           = lt_q;
  assign equal_o          = eq_q;
  assign divide_by_zero_o = dz_q;

`ifndef SYNTHESIS
  // Exactly one ordering flag describes the operand pair.
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({greater_o, less_o, equal_o}))
    else $error("comparison flags not one-hot");

  // A division by zero must deliver a zero value.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (value_o == '0))
    else $error("divide by zero with nonzero value");

  // The input is only held off while a finished beat waits.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting output beat");

  // A held output beat keeps its result through the stall.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_o)))
    else $error("stalled output beat changed");
`endif

endmodule

### sim/fpa_checker.sv
// Checker for the Q24.8 fixed-point unit: watches both channels, predicts each result
// from the accepted request and compares field by field. Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_checker
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [3:0]                 req_type_i,
  input  logic signed [WordBits-1:0] operand_a_i,
  input  logic signed [WordBits-1:0] operand_b_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [WordBits-1:0] value_i,
  input  logic                       greater_i,
  input  logic                       less_i,
  input  logic                       equal_i,
  input  logic                       divide_by_zero_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         results_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        greater;
    logic        less;
    logic        equal;
    logic        dz;
  } alu_result_t;

  alu_result_t results_due[$];

  function automatic alu_result_t compute_result(logic [3:0] op, logic signed [31:0] a,
                                                 logic signed [31:0] b);
    alu_result_t      r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r = '0;
    r.greater = a > b;
    r.less    = a < b;
    r.equal   = a == b;
    case (op)
      OP_ADD:      r.value = a + b;
      OP_SUB:      r.value = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        prod = prod >>> FRAC_BITS;
        r.value = prod[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC_BITS;
          quo = num / 64'(b);
          r.value = quo[31:0];
        end
      end
      OP_MIN:      r.value = (a < b) ? a : b;
      OP_MAX:      r.value = (a > b) ? a : b;
      OP_INC:      r.value = a + 32'sd1;
      OP_DEC:      r.value = a - 32'sd1;
      OP_FROM_INT: r.value = a <<< FRAC_BITS;
      OP_TO_INT:   r.value = a >>> FRAC_BITS;
      default:     r.value = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    alu_result_t got;
    alu_result_t want;
    if (!rst_ni) begin
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        results_due.push_back(compute_result(req_type_i, operand_a_i, operand_b_i));
      if (out_valid_i && !out_stall_i) begin
        got = {value_i, greater_i, less_i, equal_i, divide_by_zero_i};
        results_o <= results_o + 1;
        if (results_due.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("unexpected result beat %h", got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("mismatch: value %h/%h gt %b/%b lt %b/%b eq %b/%b dz %b/%b (exp/act)",
                       want.value, got.value, want.greater, got.greater, want.less,
                       got.less, want.equal, got.equal, want.dz, got.dz);
          end
        end
      end
    end
    pending_o <= results_due.size();
  end

endmodule

### sim/testbench.sv
// Top of the fixed-point unit testbench: clock, reset, request stimulus and verdict.
// Depends on fpa_pkg, fixed_point_alu_q24_8 and fpa_checker.
`timescale 1ns / 1ps
module testbench;
  import fpa_pkg::*;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [3:0]                 req_type_i = '0;
  logic signed [WordBits-1:0] operand_a_i = '0;
  logic signed [WordBits-1:0] operand_b_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [WordBits-1:0] value_o;
  logic                       greater_o, less_o, equal_o, divide_by_zero_o;
  int                         errors, pending, results;

  // Idle and stall percentages for the sender and the receiver, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent = 0;

  always #6 clk_i = ~clk_i;

  fixed_point_alu_q24_8 DUT (.*);

  fpa_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .operand_a_i,
    .operand_b_i, .out_valid_i(out_valid_o), .out_stall_i, .value_i(value_o),
    .greater_i(greater_o), .less_i(less_o), .equal_i(equal_o),
    .divide_by_zero_i(divide_by_zero_o), .errors_o(errors), .pending_o(pending),
    .results_o(results)
  );

  // The receiver stalls at random each cycle; this is independent of valid.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Random operand that often lands on an edge value, so the wrap and sign
  // corners of every operation are hit far more than uniform draws would.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(1024)) - 512);
      3: return 32'h0;
      4: return 32'(int'($urandom_range(65536)) - 32768) <<< 8;
      default: return $urandom();
    endcase
  endfunction

  // Presents one request beat and holds it until the unit accepts it. The
  // sender may idle first; valid drops only when the next beat is not ready.
  task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic random_phase(int unsigned count, int unsigned idle, int unsigned stall);
    logic [3:0]  op;
    logic [31:0] b;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      // Mostly defined opcodes, a few unknown codes.
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      b  = ($urandom_range(9) == 0) ? 32'h0 : pick_operand();
      send_request(op, pick_operand(), b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation at the extremes, divide by zero, unknown code,
    // equal operands and a negative multiply that rounds toward minus infinity.
    send_request(OP_ADD, 32'h7FFF_FFFF, 32'h1);
    send_request(OP_SUB, 32'h8000_0000, 32'h1);
    send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_MUL, 32'hFFFF_FFFF, 32'h1);
    send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_DIV, 32'h100, 32'h0);
    send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_DIV, 32'hFFFF_FF00, 32'h300);
    send_request(OP_DIV, 32'h7FFF_FFFF, 32'h1);
    send_request(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_MIN, 32'h5, 32'h5);
    send_request(OP_INC, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_DEC, 32'h8000_0000, 32'h0);
    send_request(OP_FROM_INT, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FROM_INT, 32'h8000_0001, 32'h0);
    send_request(OP_TO_INT, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_TO_INT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(4'hF, 32'h1234_5678, 32'h1234_5678);
    send_request(4'hA, 32'hFFFF_FFFF, 32'h0);

    // Random part in phases of sender idling and receiver stalls, including one with neither.
    random_phase(400, 0, 0);
    random_phase(350, 59, 0);
    random_phase(350, 0, 59);
    random_phase(400, 14, 14);
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d request beats over all ten operations and unknown codes;", beats_sent);
    $display("checked %0d result beats under four idle/stall mixes.", results);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
